>>> hw/rtl/fjr_pkg.sv
// ----------------------------------------------------------------------------
// fjr_pkg: shared types and constants
// Beat formats, configuration and state records and mode codes for the
// feeder jam recovery machine.
// ----------------------------------------------------------------------------
package fjr_pkg;

  localparam int JAM_CONFIRM_TICKS = 50;
  localparam int FEED_DIRECTION = 1;
  localparam bit CONTINUOUS_ENABLE = 1'b1;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_ADDR_W-1:0] REG_STEP_ANGLE      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BACK_OFF_ANGLE  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ARRIVE_TOL      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_JAM_SPEED_MAX   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_JAM_CURRENT_MIN = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SINGLE_TIMEOUT  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_REVERSE_TIMEOUT = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_RELOAD_TIMEOUT  = 3'd7;

  localparam logic [2:0] MODE_READY   = 3'd0;
  localparam logic [2:0] MODE_SINGLE  = 3'd1;
  localparam logic [2:0] MODE_CONT    = 3'd2;
  localparam logic [2:0] MODE_REVERSE = 3'd3;
  localparam logic [2:0] MODE_RELOAD  = 3'd4;

  typedef struct packed {
    logic signed [31:0] wheel_angle;
    logic signed [15:0] wheel_speed;
    logic signed [15:0] wheel_current;
    logic               single_edge;
    logic               continuous_req;
    logic               force_resync;
    logic        [31:0] now_ms;
  } in_beat_t;

  typedef struct packed {
    logic        [2:0]  mode;
    logic signed [31:0] target_angle;
    logic        [7:0]  jam_total;
    logic               clear_loops;
  } out_beat_t;

  typedef struct packed {
    logic [22:0] step_angle;
    logic [22:0] back_off_angle;
    logic [15:0] arrive_tolerance;
    logic [14:0] jam_speed_max;
    logic [14:0] jam_current_min;
    logic [15:0] single_timeout_ms;
    logic [15:0] reverse_timeout_ms;
    logic [15:0] reload_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] target;
    logic [63:0] feed_target;
    logic        synced;
    logic        resume_cont;
    logic [7:0]  jam_run;
    logic [7:0]  jam_count;
    logic [31:0] entry_time;
  } fsm_state_t;

endpackage

>>> hw/rtl/feeder_jam_recovery_fsm_top.sv
// ----------------------------------------------------------------------------
// feeder_jam_recovery_fsm_top: feeder wheel feed and jam recovery machine
// Path: input register, combinational state update, result register; an input beat
// waits in the input register while the result register is full and not read.
// Throughput: one beat per cycle while the receiver holds out_ready high.
// Reset: synchronous, active low; state and configuration clear, channels empty.
// ----------------------------------------------------------------------------
module feeder_jam_recovery_fsm_top
  import fjr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_beat_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t       cfg;
  logic       in_valid_r;
  in_beat_t   in_data_r;
  logic       out_valid_r;
  out_beat_t  out_data_r;
  fsm_state_t st_r;
  fsm_state_t st_nxt;
  out_beat_t  res_nxt;
  logic       fire;

  fjr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  fjr_step u_step (
    .st      (st_r),
    .cfg     (cfg),
    .in_beat (in_data_r),
    .st_nxt  (st_nxt),
    .out_beat(res_nxt)
  );

  assign fire = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      st_r <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        st_r <= st_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

>>> hw/rtl/fjr_cfg_regs.sv
// ----------------------------------------------------------------------------
// fjr_cfg_regs: configuration register file
// Write-only registers, each masked to its own width, all cleared by reset.
// ----------------------------------------------------------------------------
module fjr_cfg_regs
  import fjr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_STEP_ANGLE:      cfg_nxt.step_angle = cfg_wdata;
        REG_BACK_OFF_ANGLE:  cfg_nxt.back_off_angle = cfg_wdata;
        REG_ARRIVE_TOL:      cfg_nxt.arrive_tolerance = cfg_wdata[15:0];
        REG_JAM_SPEED_MAX:   cfg_nxt.jam_speed_max = cfg_wdata[14:0];
        REG_JAM_CURRENT_MIN: cfg_nxt.jam_current_min = cfg_wdata[14:0];
        REG_SINGLE_TIMEOUT:  cfg_nxt.single_timeout_ms = cfg_wdata[15:0];
        REG_REVERSE_TIMEOUT: cfg_nxt.reverse_timeout_ms = cfg_wdata[15:0];
        REG_RELOAD_TIMEOUT:  cfg_nxt.reload_timeout_ms = cfg_wdata[15:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/fjr_step.sv
// ----------------------------------------------------------------------------
// fjr_step: one control tick of the feed machine
// Combinational next state and result beat from the current state, the
// configuration and one input beat.
// ----------------------------------------------------------------------------
module fjr_step
  import fjr_pkg::*;
(
  input  fsm_state_t st,
  input  cfg_t       cfg,
  input  in_beat_t   in_beat,
  output fsm_state_t st_nxt,
  output out_beat_t  out_beat
);

  function automatic logic [63:0] dir_mul(input logic signed [1:0] dir,
                                          input logic [22:0] mag);
    logic [63:0] ext;
    ext = {41'b0, mag};
    if (dir > 2'sd0) begin
      return ext;
    end else if (dir < 2'sd0) begin
      return 64'd0 - ext;
    end
    return 64'd0;
  endfunction

  function automatic logic [16:0] abs16(input logic [15:0] v);
    if (v[15]) begin
      return 17'h10000 - {1'b0, v};
    end
    return {1'b0, v};
  endfunction

  logic [63:0] angle;
  logic [63:0] err;
  logic [63:0] err_mag;
  logic [16:0] spd;
  logic [16:0] cur;
  logic [31:0] elapsed;
  logic        arrived;
  logic        sus;
  logic        confirmed;
  logic        clear;
  logic        recover;
  logic        rec_cont;
  logic signed [1:0] rec_dir;
  fsm_state_t  s;

  always_comb begin
    angle = {{32{in_beat.wheel_angle[31]}}, in_beat.wheel_angle};
    spd = abs16(in_beat.wheel_speed);
    cur = abs16(in_beat.wheel_current);
    s = st;
    clear = 1'b0;
    recover = 1'b0;
    rec_cont = 1'b0;
    confirmed = 1'b0;

    if (in_beat.force_resync) begin
      s.synced = 1'b0;
    end
    if (!s.synced) begin
      s.target = angle;
      s.feed_target = angle;
      s.synced = 1'b1;
      s.mode = in_beat.continuous_req ? MODE_CONT : MODE_READY;
      s.entry_time = in_beat.now_ms;
      clear = 1'b1;
    end

    err = s.target - angle;
    err_mag = err[63] ? (64'd0 - err) : err;
    arrived = (err_mag <= {48'b0, cfg.arrive_tolerance});
    elapsed = in_beat.now_ms - s.entry_time;

    sus = (spd <= {2'b0, cfg.jam_speed_max}) && (cur >= {2'b0, cfg.jam_current_min});

    unique case (s.mode)
      MODE_READY: begin
        if (in_beat.single_edge) begin
          s.target = s.target + dir_mul(2'(FEED_DIRECTION), cfg.step_angle);
          s.feed_target = s.target;
          s.mode = MODE_SINGLE;
          s.entry_time = in_beat.now_ms;
          s.jam_run = 8'd0;
          clear = 1'b1;
        end else if (CONTINUOUS_ENABLE && in_beat.continuous_req) begin
          s.target = angle;
          s.feed_target = angle;
          s.mode = MODE_CONT;
          s.entry_time = in_beat.now_ms;
          s.jam_run = 8'd0;
          clear = 1'b1;
        end
      end
      MODE_SINGLE: begin
        if (sus && !arrived) begin
          if (s.jam_run < 8'(JAM_CONFIRM_TICKS)) begin
            s.jam_run = s.jam_run + 8'd1;
          end
        end else begin
          s.jam_run = 8'd0;
        end
        confirmed = (s.jam_run >= 8'(JAM_CONFIRM_TICKS));
        if (confirmed) begin
          recover = 1'b1;
        end else if (arrived || (elapsed >= {16'b0, cfg.single_timeout_ms})) begin
          s.mode = MODE_READY;
          s.entry_time = in_beat.now_ms;
          s.jam_run = 8'd0;
          s.jam_count = 8'd0;
          clear = 1'b1;
        end
      end
      MODE_CONT: begin
        if (!in_beat.continuous_req) begin
          s.mode = MODE_READY;
          s.synced = 1'b0;
          clear = 1'b1;
        end else if (CONTINUOUS_ENABLE) begin
          if (sus) begin
            if (s.jam_run < 8'(JAM_CONFIRM_TICKS)) begin
              s.jam_run = s.jam_run + 8'd1;
            end
          end else begin
            s.jam_run = 8'd0;
          end
          if (s.jam_run >= 8'(JAM_CONFIRM_TICKS)) begin
            recover = 1'b1;
            rec_cont = 1'b1;
          end
        end
      end
      MODE_REVERSE: begin
        if (arrived || (elapsed >= {16'b0, cfg.reverse_timeout_ms})) begin
          s.target = s.feed_target;
          s.mode = MODE_RELOAD;
          s.entry_time = in_beat.now_ms;
          clear = 1'b1;
        end
      end
      MODE_RELOAD: begin
        if (arrived || (elapsed >= {16'b0, cfg.reload_timeout_ms})) begin
          s.jam_run = 8'd0;
          if (s.resume_cont) begin
            s.mode = MODE_CONT;
          end else begin
            s.mode = MODE_READY;
            s.jam_count = 8'd0;
          end
          s.entry_time = in_beat.now_ms;
          clear = 1'b1;
        end
      end
      default: begin
        s.mode = MODE_READY;
        s.synced = 1'b0;
      end
    endcase

    rec_dir = rec_cont ? 2'(FEED_DIRECTION) : (err[63] ? -2'sd1 : 2'sd1);
    if (recover) begin
      s.resume_cont = rec_cont;
      s.feed_target = rec_cont ? angle : s.target;
      s.target = angle - dir_mul(rec_dir, cfg.back_off_angle);
      s.mode = MODE_REVERSE;
      s.entry_time = in_beat.now_ms;
      s.jam_run = 8'd0;
      s.jam_count = s.jam_count + 8'd1;
      clear = 1'b1;
    end

    st_nxt = s;
    out_beat.mode = s.mode;
    out_beat.target_angle = s.target[31:0];
    out_beat.jam_total = s.jam_count;
    out_beat.clear_loops = clear;
  end

endmodule

>>> sim/tb_feeder_jam_recovery_fsm_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_feeder_jam_recovery_fsm_top: self-checking bench for the feed machine
// A queue of control ticks feeds a valid/ready driver. A clocked predictor
// works out each expected result beat when its tick is accepted, and the
// monitor checks every result beat against it, field by field. After a short
// directed run, phases of single shots, continuous runs, jams with back-off
// and reload, noise and broken sequences follow under several register
// settings. Both sides idle and stall at random, and the receiver holds off
// for long stretches.
// ----------------------------------------------------------------------------
module tb_feeder_jam_recovery_fsm_top;
  import fjr_pkg::*;

  typedef enum {
    SET_TYPICAL,
    SET_SHORT_TIMEOUTS,
    SET_ALL_MAX,
    SET_ALL_ZERO,
    SET_RANDOM
  } setting_e;

  localparam int HOLD_CYCLES = 300;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_beat_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  feeder_jam_recovery_fsm_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted machine state and register copy.
  cfg_t        cfg_now = '0;
  logic [2:0]  fsm_mode = MODE_READY;
  logic [63:0] aim = '0;
  logic [63:0] aim_feed = '0;
  logic        locked = 1'b0;
  logic        back_to_cont = 1'b0;
  logic [7:0]  jam_streak = '0;
  logic [7:0]  jam_tally = '0;
  logic [31:0] mark_ms = '0;
  logic        clr_now = 1'b0;

  in_beat_t    tick_q[$];
  out_beat_t   due_results[$];
  int          ticks_queued = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          fault_cnt = 0;
  int          n_settings = 0;
  int          n_single = 0;
  int          n_cont = 0;
  int          n_jam_single = 0;
  int          n_jam_cont = 0;

  int          gap_left = 0;
  bit          send_burst = 1'b0;
  int          stall_left = 0;
  bit          recv_burst = 1'b0;
  int          hold_left = 0;
  logic        hold_kick = 1'b0;

  logic signed [31:0] wheel = '0;
  logic        [31:0] clock_ms = '0;

  function automatic logic [63:0] signed_span(int dir, logic [22:0] mag);
    return 64'(longint'(dir) * longint'({1'b0, mag}));
  endfunction

  function automatic bit at_target(logic [63:0] ang);
    logic [63:0] d;
    d = aim - ang;
    if (d[63]) d = 64'd0 - d;
    return d <= 64'(cfg_now.arrive_tolerance);
  endfunction

  function automatic bit jam_seen(bit moving, logic [16:0] spd, logic [16:0] cur);
    bit sus;
    sus = moving && spd <= cfg_now.jam_speed_max && cur >= cfg_now.jam_current_min;
    if (sus) begin
      if (jam_streak < JAM_CONFIRM_TICKS) jam_streak = jam_streak + 8'd1;
    end else begin
      jam_streak = '0;
    end
    return jam_streak >= JAM_CONFIRM_TICKS;
  endfunction

  function automatic void start_back_off(bit from_cont, logic [63:0] ang, logic [31:0] now);
    logic [63:0] err;
    int dir;
    err = aim - ang;
    back_to_cont = from_cont;
    aim_feed = from_cont ? ang : aim;
    dir = from_cont ? FEED_DIRECTION : (err[63] ? -1 : 1);
    aim = ang - signed_span(dir, cfg_now.back_off_angle);
    fsm_mode = MODE_REVERSE;
    mark_ms = now;
    jam_streak = '0;
    jam_tally = jam_tally + 8'd1;
    clr_now = 1'b1;
    if (from_cont) n_jam_cont++;
    else n_jam_single++;
  endfunction

  function automatic out_beat_t feeder_tick(in_beat_t b);
    logic [63:0] ang;
    logic [16:0] spd;
    logic [16:0] cur;
    out_beat_t   r;
    ang = {{32{b.wheel_angle[31]}}, b.wheel_angle[31:0]};
    spd = b.wheel_speed[15] ? 17'h10000 - {1'b0, b.wheel_speed[15:0]}
                            : {1'b0, b.wheel_speed[15:0]};
    cur = b.wheel_current[15] ? 17'h10000 - {1'b0, b.wheel_current[15:0]}
                              : {1'b0, b.wheel_current[15:0]};
    clr_now = 1'b0;
    if (b.force_resync) locked = 1'b0;
    if (!locked) begin
      aim = ang;
      aim_feed = ang;
      locked = 1'b1;
      fsm_mode = b.continuous_req ? MODE_CONT : MODE_READY;
      mark_ms = b.now_ms;
      clr_now = 1'b1;
    end
    case (fsm_mode)
      MODE_READY: begin
        if (b.single_edge) begin
          aim = aim + signed_span(FEED_DIRECTION, cfg_now.step_angle);
          aim_feed = aim;
          fsm_mode = MODE_SINGLE;
          mark_ms = b.now_ms;
          jam_streak = '0;
          clr_now = 1'b1;
          n_single++;
        end else if (CONTINUOUS_ENABLE && b.continuous_req) begin
          aim = ang;
          aim_feed = ang;
          fsm_mode = MODE_CONT;
          mark_ms = b.now_ms;
          jam_streak = '0;
          clr_now = 1'b1;
          n_cont++;
        end
      end
      MODE_SINGLE: begin
        if (jam_seen(!at_target(ang), spd, cur)) begin
          start_back_off(1'b0, ang, b.now_ms);
        end else if (at_target(ang) ||
                     (b.now_ms - mark_ms) >= 32'(cfg_now.single_timeout_ms)) begin
          fsm_mode = MODE_READY;
          mark_ms = b.now_ms;
          jam_streak = '0;
          jam_tally = '0;
          clr_now = 1'b1;
        end
      end
      MODE_CONT: begin
        if (!b.continuous_req) begin
          fsm_mode = MODE_READY;
          locked = 1'b0;
          clr_now = 1'b1;
        end else if (CONTINUOUS_ENABLE && jam_seen(1'b1, spd, cur)) begin
          start_back_off(1'b1, ang, b.now_ms);
        end
      end
      MODE_REVERSE: begin
        if (at_target(ang) || (b.now_ms - mark_ms) >= 32'(cfg_now.reverse_timeout_ms)) begin
          aim = aim_feed;
          fsm_mode = MODE_RELOAD;
          mark_ms = b.now_ms;
          clr_now = 1'b1;
        end
      end
      MODE_RELOAD: begin
        if (at_target(ang) || (b.now_ms - mark_ms) >= 32'(cfg_now.reload_timeout_ms)) begin
          jam_streak = '0;
          if (back_to_cont) begin
            fsm_mode = MODE_CONT;
          end else begin
            fsm_mode = MODE_READY;
            jam_tally = '0;
          end
          mark_ms = b.now_ms;
          clr_now = 1'b1;
        end
      end
      default: begin
        fsm_mode = MODE_READY;
        locked = 1'b0;
      end
    endcase
    r.mode = fsm_mode;
    r.target_angle = aim[31:0];
    r.jam_total = jam_tally;
    r.clear_loops = clr_now;
    return r;
  endfunction

  task automatic note_fault(string msg);
    fault_cnt++;
    if (fault_cnt <= 10) $display("ERROR: %s", msg);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      note_fault($sformatf("result beat %0d, %s: expected 0x%0h, got 0x%0h",
                           beats_out, what, want, got));
    end
  endtask

  always @(posedge clk) begin : drive_ticks
    logic     vld_n;
    in_beat_t dat_n;
    vld_n = in_valid;
    dat_n = in_data;
    if (!rst_n) begin
      vld_n = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_results.push_back(feeder_tick(in_data));
        beats_in++;
        vld_n = 1'b0;
      end
      if (!vld_n) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (tick_q.size() != 0) begin
          dat_n = tick_q.pop_front();
          vld_n = 1'b1;
          if ($urandom_range(49, 0) == 0) send_burst = !send_burst;
          gap_left = send_burst ? 0 : $urandom_range(13, 0);
        end
      end
    end
    in_valid <= vld_n;
    in_data <= dat_n;
  end

  always @(posedge clk) begin : watch_results
    out_beat_t want;
    logic      rdy_n;
    rdy_n = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          note_fault($sformatf("result beat %0d arrived with nothing expected", beats_out));
        end else begin
          want = due_results.pop_front();
          check_field("mode", 32'(out_data.mode), 32'(want.mode));
          check_field("target_angle", out_data.target_angle, want.target_angle);
          check_field("jam_total", 32'(out_data.jam_total), 32'(want.jam_total));
          check_field("clear_loops", 32'(out_data.clear_loops), 32'(want.clear_loops));
        end
        beats_out++;
        if ($urandom_range(49, 0) == 0) recv_burst = !recv_burst;
        stall_left = recv_burst ? 0 : $urandom_range(13, 0);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      rdy_n = (stall_left == 0) && (hold_left == 0);
    end
    out_ready <= rdy_n;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic put_raw(logic signed [31:0] ang, logic [15:0] spd, logic [15:0] cur,
                         bit sh, bit cr, bit rs, logic [31:0] now);
    in_beat_t b;
    b.wheel_angle = ang;
    b.wheel_speed = spd;
    b.wheel_current = cur;
    b.single_edge = sh;
    b.continuous_req = cr;
    b.force_resync = rs;
    b.now_ms = now;
    tick_q.push_back(b);
    ticks_queued++;
  endtask

  task automatic put_tick(logic signed [31:0] ang, bit jammed, bit sh, bit cr, bit rs);
    int spd;
    int cur;
    int jsm;
    int jcm;
    jsm = cfg_now.jam_speed_max;
    jcm = cfg_now.jam_current_min;
    if (jammed) begin
      spd = $urandom_range(jsm, 0);
      cur = $urandom_range(32768, jcm);
    end else begin
      spd = $urandom_range(32767, jsm < 32767 ? jsm + 1 : 0);
      cur = $urandom_range(jcm > 0 ? jcm - 1 : 0, 0);
    end
    if ($urandom_range(1, 0) != 0) spd = -spd;
    if ($urandom_range(1, 0) != 0) cur = -cur;
    if ($urandom_range(9, 0) == 0) clock_ms += $urandom_range(3, 0);
    else clock_ms += 1;
    wheel = ang;
    put_raw(ang, 16'(spd), 16'(cur), sh, cr, rs, clock_ms);
  endtask

  task automatic glide(logic signed [31:0] dest, int n, bit cr);
    logic signed [31:0] from;
    logic signed [31:0] travel;
    longint             off;
    from = wheel;
    travel = dest - from;
    for (int i = 1; i <= n; i++) begin
      off = longint'(travel) * i / n;
      put_tick(from + off[31:0], 1'b0, 1'b0, cr, 1'b0);
    end
  endtask

  task automatic put_noise();
    logic [31:0] now;
    now = ($urandom_range(3, 0) == 0) ? $urandom : clock_ms + 32'd1;
    clock_ms = now;
    put_raw($urandom, 16'($urandom), 16'($urandom), 1'($urandom_range(1, 0)),
            1'($urandom_range(1, 0)), $urandom_range(7, 0) == 0, now);
  endtask

  task automatic put_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
  endtask

  task automatic put_regs(cfg_t c);
    cfg_now = c;
    n_settings++;
    put_reg(REG_STEP_ANGLE, c.step_angle);
    put_reg(REG_BACK_OFF_ANGLE, c.back_off_angle);
    put_reg(REG_ARRIVE_TOL, 23'(c.arrive_tolerance));
    put_reg(REG_JAM_SPEED_MAX, 23'(c.jam_speed_max));
    put_reg(REG_JAM_CURRENT_MIN, 23'(c.jam_current_min));
    put_reg(REG_SINGLE_TIMEOUT, 23'(c.single_timeout_ms));
    put_reg(REG_REVERSE_TIMEOUT, 23'(c.reverse_timeout_ms));
    put_reg(REG_RELOAD_TIMEOUT, 23'(c.reload_timeout_ms));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (!(beats_in == ticks_queued && due_results.size() == 0)) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(setting_e kind, int n_items, bit squeeze);
    cfg_t               c;
    int                 stop_at;
    int                 pick;
    logic signed [31:0] start;
    logic signed [31:0] aim_pos;
    logic signed [31:0] over;
    logic signed [31:0] back_dest;
    case (kind)
      SET_TYPICAL, SET_SHORT_TIMEOUTS: begin
        c.step_angle = 23'($urandom_range(20000, 1000));
        c.back_off_angle = 23'($urandom_range(5000, 500));
        c.arrive_tolerance = 16'($urandom_range(50, 0));
        c.jam_speed_max = 15'($urandom_range(500, 100));
        c.jam_current_min = 15'($urandom_range(5000, 2000));
        if (kind == SET_TYPICAL) begin
          c.single_timeout_ms = 16'($urandom_range(2000, 200));
          c.reverse_timeout_ms = 16'($urandom_range(100, 5));
          c.reload_timeout_ms = 16'($urandom_range(100, 5));
        end else begin
          c.single_timeout_ms = 16'($urandom_range(8, 0));
          c.reverse_timeout_ms = 16'($urandom_range(8, 0));
          c.reload_timeout_ms = 16'($urandom_range(8, 0));
        end
      end
      SET_ALL_MAX: c = '1;
      SET_ALL_ZERO: c = '0;
      default: c = {$urandom, $urandom, $urandom, $urandom, 12'($urandom)};
    endcase
    put_regs(c);
    clock_ms = ($urandom_range(3, 0) == 0) ? 32'hFFFF_FF80 : $urandom;
    case ($urandom_range(2, 0))
      0: wheel = 32'sh7FFF_F000;
      1: wheel = 32'sh8000_0400;
      default: wheel = $urandom;
    endcase
    stop_at = ticks_queued + n_items;
    put_tick(wheel, 1'b0, 1'b0, 1'b0, 1'b1);
    while (ticks_queued < stop_at) begin
      pick = $urandom_range(99, 0);
      if (pick < 25) begin
        start = wheel;
        put_tick(wheel, 1'b0, 1'b1, 1'b0, $urandom_range(3, 0) == 0);
        glide(start + 32'(c.step_angle), $urandom_range(6, 1), 1'b0);
        repeat ($urandom_range(2, 0)) put_tick(wheel, 1'b0, 1'b0, 1'b0, 1'b0);
      end else if (pick < 45) begin
        start = wheel;
        aim_pos = start + 32'(c.step_angle);
        put_tick(wheel, 1'b0, 1'b1, 1'b0, 1'b0);
        over = ($urandom_range(2, 0) == 0) ? aim_pos + 32'sd5000 : start;
        back_dest = (over == start) ? over - 32'(c.back_off_angle)
                                    : over + 32'(c.back_off_angle);
        repeat ($urandom_range(56, 50)) put_tick(over, 1'b1, 1'b0, 1'b0, 1'b0);
        glide(back_dest, $urandom_range(5, 2), 1'b0);
        glide(aim_pos, $urandom_range(6, 2), 1'b0);
        repeat ($urandom_range(2, 0)) put_tick(wheel, 1'b0, 1'b0, 1'b0, 1'b0);
      end else if (pick < 70) begin
        put_tick(wheel, 1'b0, 1'b0, 1'b1, 1'b0);
        glide(wheel + 32'($urandom_range(50000, 0)), $urandom_range(20, 3), 1'b1);
        if ($urandom_range(1, 0) != 0) begin
          start = wheel;
          repeat ($urandom_range(54, 50)) put_tick(start, 1'b1, 1'b0, 1'b1, 1'b0);
          glide(start - 32'(c.back_off_angle), $urandom_range(5, 2), 1'b1);
          glide(start, $urandom_range(5, 2), 1'b1);
          glide(wheel + 32'($urandom_range(20000, 0)), $urandom_range(8, 1), 1'b1);
        end
        put_tick(wheel, 1'b0, 1'b0, 1'b0, 1'b0);
      end else if (pick < 85) begin
        repeat ($urandom_range(5, 1)) put_noise();
      end else if ($urandom_range(1, 0) != 0) begin
        // Interrupted jam run, then at random a resync while the shot is still under way.
        start = wheel;
        put_tick(wheel, 1'b0, 1'b1, 1'b0, 1'b0);
        repeat ($urandom_range(45, 20)) put_tick(start, 1'b1, 1'b0, 1'b0, 1'b0);
        put_tick(start, 1'b0, 1'b0, 1'b0, 1'b0);
        repeat ($urandom_range(10, 3)) put_tick(start, 1'b1, 1'b0, 1'b0, 1'b0);
        put_tick(start, 1'b0, 1'b0, 1'b0, 1'($urandom_range(1, 0)));
        glide(start + 32'(c.step_angle), $urandom_range(4, 1), 1'b0);
      end else begin
        // Continuous request dropped while the back-off is still running.
        put_tick(wheel, 1'b0, 1'b0, 1'b1, 1'b0);
        start = wheel;
        repeat ($urandom_range(52, 50)) put_tick(start, 1'b1, 1'b0, 1'b1, 1'b0);
        glide(start - 32'(c.back_off_angle), $urandom_range(4, 1), 1'b0);
        glide(start, $urandom_range(4, 1), 1'b0);
        repeat ($urandom_range(3, 1)) put_tick(wheel, 1'b0, 1'b0, 1'b0, 1'b0);
      end
    end
    if (squeeze) begin
      @(posedge clk);
      hold_kick <= 1'b1;
      @(posedge clk);
      hold_kick <= 1'b0;
    end
    wait_drained();
  endtask

  initial begin : stimulus
    cfg_t     c;
    setting_e plan [7];
    plan = '{SET_TYPICAL, SET_SHORT_TIMEOUTS, SET_ALL_MAX, SET_TYPICAL, SET_ALL_ZERO,
             SET_RANDOM, SET_TYPICAL};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Registers still at their reset values: zero step, zero tolerance, zero timeouts.
    put_raw(32'sh7FFF_FFFF, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 1'b0, 32'd0);
    put_raw(32'sh7FFF_FFFF, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 1'b0, 32'd1);
    put_raw(32'sh7FFF_FFFF, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 32'd2);
    put_raw(32'sh0000_1234, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0, 32'd3);
    put_raw(32'sh0000_1234, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0, 32'd4);
    put_raw(32'sh0000_1234, 16'h0001, 16'h7FFF, 1'b0, 1'b0, 1'b0, 32'd5);
    put_raw(32'sh8000_0000, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
    put_raw(32'sh8000_0000, 16'h8001, 16'hFFFF, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF);
    put_raw(32'sh0000_0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 32'd5);
    put_raw(32'sh0000_0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0, 32'd6);
    put_raw(32'sh0000_0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0, 32'd7);
    wait_drained();

    c = '1;
    c.arrive_tolerance = '0;
    c.single_timeout_ms = '0;
    c.reverse_timeout_ms = '0;
    c.reload_timeout_ms = '0;
    put_regs(c);
    put_raw(32'sh7FFF_FF00, 16'h0000, 16'h8000, 1'b0, 1'b1, 1'b1, 32'hAAAA_5555);
    put_raw(32'sh7FFF_FF00, 16'h8000, 16'h8000, 1'b0, 1'b0, 1'b0, 32'h5555_AAAA);
    put_raw(32'sh7FFF_FFFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 1'b0, 32'h5555_AAAB);
    put_raw(32'sh7FFF_FFFF, 16'h8000, 16'h8000, 1'b0, 1'b0, 1'b0, 32'h5555_AAAC);
    put_raw(32'shFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    put_raw(32'sh0000_0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 32'h0000_0000);
    wait_drained();

    foreach (plan[i]) run_phase(plan[i], 225, i == 1 || i == 4);

    repeat (8) @(posedge clk);
    if (due_results.size() != 0) begin
      note_fault($sformatf("%0d expected result beats never arrived", due_results.size()));
    end
    $display("tb: %0d ticks in, %0d result beats checked, %0d register settings",
             beats_in, beats_out, n_settings);
    $display("tb: %0d single shots, %0d continuous runs, jams recovered: %0d single, %0d cont",
             n_single, n_cont, n_jam_single, n_jam_cont);
    if (fault_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d faults", fault_cnt);
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("tb: timed out");
    $display("tb: failure");
    $finish;
  end

endmodule

>>> feeder_jam_recovery_fsm_top.f
hw/rtl/fjr_pkg.sv
hw/rtl/fjr_cfg_regs.sv
hw/rtl/fjr_step.sv
hw/rtl/feeder_jam_recovery_fsm_top.sv
sim/tb_feeder_jam_recovery_fsm_top.sv
